FILE: src/msds_pkg.sv
// Package for the motor shield direction shifter.
// Holds command kinds, shadow bit masks and the job record passed front to back.
// No dependencies.
`timescale 1ns / 1ps

package msds_pkg;

  typedef enum logic [1:0] {
    KIND_MOTOR_EN   = 2'd0,
    KIND_MOTOR_RUN  = 2'd1,
    KIND_STEP_EN    = 2'd2,
    KIND_STEP_BITS  = 2'd3
  } kind_e;

  localparam int unsigned QueueDepth = 2;

  localparam logic [6:0] DutyMax       = 7'd100;
  localparam logic [7:0] Step2Mask     = 8'hE1;
  localparam logic [3:0] Motor34Mask   = 4'hC;
  localparam logic [2:0] StepperTwo    = 3'd2;
  localparam logic [2:0] MotorUnitMax  = 3'd4;
  localparam logic [3:0] LatchIdx      = 4'd8;

  typedef struct packed {
    logic       shift;
    logic [7:0] shadow;
    logic       duty_cmd;
    logic [2:0] chan;
    logic [6:0] duty;
    logic       pins;
  } job_t;

  function automatic logic [7:0] motor_mask_a(input logic [1:0] m);
    logic [7:0] r;
    case (m)
      2'd0:    r = 8'h04;
      2'd1:    r = 8'h02;
      2'd2:    r = 8'h01;
      default: r = 8'h20;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] motor_mask_b(input logic [1:0] m);
    logic [7:0] r;
    case (m)
      2'd0:    r = 8'h08;
      2'd1:    r = 8'h10;
      2'd2:    r = 8'h40;
      default: r = 8'h80;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] coil_bits(input logic [3:0] nib);
    return {nib[3], nib[1], nib[2], 4'b0000, nib[0]};
  endfunction

endpackage

FILE: src/msds_if.sv
// Handshake channels of the direction shifter: command in, result out.
// Depends on nothing.
`timescale 1ns / 1ps

interface msds_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [2:0] unit;
  logic [7:0] duty_percent;
  logic       turn_dir;
  logic [3:0] coil_nibble;

  modport source(output valid, kind, unit, duty_percent, turn_dir, coil_nibble, input ready);
  modport sink(input valid, kind, unit, duty_percent, turn_dir, coil_nibble, output ready);
endinterface

interface msds_res_if;
  logic       valid;
  logic       ready;
  logic       ser_bit;
  logic       is_latch;
  logic       accepted;
  logic       duty_write;
  logic [2:0] duty_channel;
  logic [6:0] duty_value;
  logic       stepper_pins_on;
  logic       last;

  modport source(output valid, ser_bit, is_latch, accepted, duty_write, duty_channel,
                 duty_value, stepper_pins_on, last, input ready);
  modport sink(input valid, ser_bit, is_latch, accepted, duty_write, duty_channel,
               duty_value, stepper_pins_on, last, output ready);
endinterface

FILE: src/msds_front.sv
// Command front end: conflict and enable checks, shadow and flag update.
// Depends on msds_pkg and msds_cmd_if; emits one job per command.
`timescale 1ns / 1ps

module msds_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  msds_cmd_if.sink      cmd_i,
  input  logic          full_i,
  output logic          push_o,
  output msds_pkg::job_t job_o
);

  logic [7:0] shadow_q, shadow_d;
  logic [3:0] motor_en_q, motor_en_d;
  logic       step2_en_q, step2_en_d;

  logic       take;
  logic       ok;
  logic       motor_unit;
  logic [1:0] m;
  logic [7:0] mask_ab;
  logic [6:0] duty_sat;

  assign cmd_i.ready = !full_i;
  assign take        = cmd_i.valid && !full_i;
  assign push_o      = take;

  assign motor_unit = (cmd_i.unit != 3'd0) && (cmd_i.unit <= msds_pkg::MotorUnitMax);
  assign m          = 2'(cmd_i.unit - 3'd1);
  assign mask_ab    = msds_pkg::motor_mask_a(m) | msds_pkg::motor_mask_b(m);
  assign duty_sat   = (cmd_i.duty_percent > 8'(msds_pkg::DutyMax)) ? msds_pkg::DutyMax
                                                                   : cmd_i.duty_percent[6:0];

  always_comb begin
    ok          = 1'b0;
    shadow_d    = shadow_q;
    motor_en_d  = motor_en_q;
    step2_en_d  = step2_en_q;
    job_o       = '0;
    case (msds_pkg::kind_e'(cmd_i.kind))
      msds_pkg::KIND_MOTOR_EN: begin
        ok = motor_unit && !(m[1] && step2_en_q);
        shadow_d      = shadow_q & ~mask_ab;
        motor_en_d[m] = 1'b1;
      end
      msds_pkg::KIND_MOTOR_RUN: begin
        ok = motor_unit && motor_en_q[m];
        shadow_d = (shadow_q & ~mask_ab)
                 | (cmd_i.turn_dir ? msds_pkg::motor_mask_a(m) : msds_pkg::motor_mask_b(m));
        job_o.duty_cmd = 1'b1;
        job_o.chan     = cmd_i.unit;
        job_o.duty     = duty_sat;
      end
      msds_pkg::KIND_STEP_EN: begin
        ok = (cmd_i.unit == msds_pkg::StepperTwo)
          && ((motor_en_q & msds_pkg::Motor34Mask) == 4'd0);
        shadow_d   = shadow_q & ~msds_pkg::Step2Mask;
        step2_en_d = 1'b1;
        job_o.pins = 1'b1;
      end
      msds_pkg::KIND_STEP_BITS: begin
        ok = (cmd_i.unit == msds_pkg::StepperTwo) && step2_en_q;
        shadow_d = (shadow_q & ~msds_pkg::Step2Mask) | msds_pkg::coil_bits(cmd_i.coil_nibble);
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    if (!ok) begin
      shadow_d   = shadow_q;
      motor_en_d = motor_en_q;
      step2_en_d = step2_en_q;
      job_o      = '0;
    end else begin
      job_o.shift  = 1'b1;
      job_o.shadow = shadow_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_q   <= '0;
      motor_en_q <= '0;
      step2_en_q <= 1'b0;
    end else if (take) begin
      shadow_q   <= shadow_d;
      motor_en_q <= motor_en_d;
      step2_en_q <= step2_en_d;
    end
  end

endmodule

FILE: src/msds_queue.sv
// Short job queue between the front end and the shift sequencer.
// Depends on msds_pkg for the job record.
`timescale 1ns / 1ps

module msds_queue #(
  parameter int unsigned Depth = msds_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  msds_pkg::job_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output msds_pkg::job_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  msds_pkg::job_t  mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrLast) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrLast) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

FILE: src/msds_back.sv
// Shift sequencer: turns each job into eight serial bit items and a latch item.
// Depends on msds_pkg and msds_res_if; a rejected job gives one closing item.
`timescale 1ns / 1ps

module msds_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  msds_pkg::job_t job_i,
  output logic           pop_o,
  msds_res_if.source     res_o
);

  msds_pkg::job_t job_q, job_d;
  logic           busy_q, busy_d;
  logic [3:0]     idx_q, idx_d;

  logic           out_valid_q, out_valid_d;
  logic           ser_q, ser_d, latch_q, latch_d, acc_q, acc_d, dw_q, dw_d;
  logic [2:0]     ch_q, ch_d;
  logic [6:0]     dv_q, dv_d;
  logic           pins_q, pins_d, last_q, last_d;

  logic           load;
  logic           final_item;

  assign load       = !out_valid_q || res_o.ready;
  assign final_item = !job_q.shift || (idx_q == msds_pkg::LatchIdx);

  always_comb begin
    job_d       = job_q;
    busy_d      = busy_q;
    idx_d       = idx_q;
    pop_o       = 1'b0;
    out_valid_d = out_valid_q && !res_o.ready;
    ser_d   = ser_q;
    latch_d = latch_q;
    acc_d   = acc_q;
    dw_d    = dw_q;
    ch_d    = ch_q;
    dv_d    = dv_q;
    pins_d  = pins_q;
    last_d  = last_q;
    if (load) begin
      if (busy_q) begin
        out_valid_d = 1'b1;
        ser_d   = 1'b0;
        latch_d = 1'b0;
        acc_d   = 1'b0;
        dw_d    = 1'b0;
        ch_d    = '0;
        dv_d    = '0;
        pins_d  = 1'b0;
        last_d  = final_item;
        if (job_q.shift) begin
          if (idx_q == msds_pkg::LatchIdx) begin
            latch_d = 1'b1;
            acc_d   = 1'b1;
            dw_d    = job_q.duty_cmd;
            ch_d    = job_q.chan;
            dv_d    = job_q.duty;
            pins_d  = job_q.pins;
          end else begin
            ser_d = job_q.shadow[3'(3'd7 - idx_q[2:0])];
            if (idx_q == 4'd0) begin
              dw_d = job_q.duty_cmd;
              ch_d = job_q.chan;
            end
          end
        end
        if (final_item) begin
          pop_o  = valid_i;
          busy_d = valid_i;
          job_d  = job_i;
          idx_d  = '0;
        end else begin
          idx_d = idx_q + 4'd1;
        end
      end else begin
        pop_o  = valid_i;
        busy_d = valid_i;
        job_d  = job_i;
        idx_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q   <= job_d;
    ser_q   <= ser_d;
    latch_q <= latch_d;
    acc_q   <= acc_d;
    dw_q    <= dw_d;
    ch_q    <= ch_d;
    dv_q    <= dv_d;
    pins_q  <= pins_d;
    last_q  <= last_d;
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.ser_bit         = ser_q;
  assign res_o.is_latch        = latch_q;
  assign res_o.accepted        = acc_q;
  assign res_o.duty_write      = dw_q;
  assign res_o.duty_channel    = ch_q;
  assign res_o.duty_value      = dv_q;
  assign res_o.stepper_pins_on = pins_q;
  assign res_o.last            = last_q;

endmodule

FILE: src/motor_shield_direction_shifter_top.sv
// Top level of the motor shield direction shifter.
// Depends on msds_pkg, msds_if, msds_front, msds_queue and msds_back.
//
// Usage:
//   cmd_i carries motor enable, motor run, stepper enable and stepper bits
//   commands; res_o carries the items of each command, the final one marked
//   by last. An accepted command gives eight serial bit items (MSB first)
//   and a latch item; a refused command gives one item with only last set.
//   The first item of a command passes through the queue, then the sequencer's
//   job register and then its output register before it shows on res_o.
//   Throughput: one result item per cycle while res_o is ready, a rate set by
//   the shift sequencer. Items of consecutive commands follow with no gap.
//   Commands are checked and the shadow updated at acceptance; up to
//   QueueDepth checked commands wait while the sequencer is busy, and
//   cmd_i.ready drops only when that queue is full.
//   Reset clears the shadow, the motor flags, the stepper 2 flag and the
//   queue. A stalled res_o holds its item; the queue keeps filling.
`timescale 1ns / 1ps

module motor_shield_direction_shifter_top #(
  parameter int unsigned QueueDepth = msds_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  msds_cmd_if.sink   cmd_i,
  msds_res_if.source res_o
);

  logic           push;
  logic           full;
  logic           pop;
  logic           q_valid;
  msds_pkg::job_t job_in;
  msds_pkg::job_t job_out;

  msds_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_i),
    .full_i (full),
    .push_o (push),
    .job_o  (job_in)
  );

  msds_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (job_out)
  );

  msds_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .job_i   (job_out),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule

FILE: verif/motor_shield_direction_shifter_top_test.sv
// Self-checking bench for motor_shield_direction_shifter_top: a directed and a random command
// stream, a bridge-shadow predictor and an in-order result check with random stalls on both sides.
// Depends on msds_pkg, msds_if and the RTL of the direction shifter.
`timescale 1ns / 1ps

module motor_shield_direction_shifter_top_test;

  localparam int unsigned CycleLimit = 800_000;
  localparam int unsigned RandomCmds = 460;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned HoldAfterCmds = 200;
  // A and B lines per motor, motor 1 in the low byte
  localparam logic [31:0] LineA = {8'h20, 8'h01, 8'h02, 8'h04};
  localparam logic [31:0] LineB = {8'h80, 8'h40, 8'h10, 8'h08};

  typedef struct packed {
    msds_pkg::kind_e kind;
    logic [2:0]      unit;
    logic [7:0]      duty_percent;
    logic            turn_dir;
    logic [3:0]      coil_nibble;
  } cmd_t;

  typedef struct packed {
    logic       ser_bit;
    logic       is_latch;
    logic       accepted;
    logic       duty_write;
    logic [2:0] duty_channel;
    logic [6:0] duty_value;
    logic       stepper_pins_on;
    logic       last;
  } res_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  msds_cmd_if cmd_if ();
  msds_res_if res_if ();

  motor_shield_direction_shifter_top dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if),
    .res_o (res_if)
  );

  always #10 clk_i = ~clk_i;

  // bridge state as the block should hold it
  logic [7:0] bridge_shadow;
  logic [3:0] motor_on;
  logic       stepper_two_on;

  cmd_t pending_q[$];
  res_t serial_q[$];
  cmd_t cur_cmd;

  int unsigned cycle_count = 0;
  int unsigned cmds_taken = 0;
  int unsigned cmds_ok = 0;
  int unsigned cmds_refused = 0;
  int unsigned duty_runs = 0;
  int unsigned items_checked = 0;
  int unsigned errors = 0;
  int unsigned send_gap;
  int unsigned recv_gap;
  int unsigned hold_cnt;
  logic        hold_off;
  logic        hold_done;
  logic        next_valid;
  bit          stepper_side;

  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic cmd_t mk_cmd(input msds_pkg::kind_e k, input int u, input int d,
                                  input bit dir, input int nib);
    cmd_t c;
    c.kind = k;
    c.unit = u[2:0];
    c.duty_percent = d[7:0];
    c.turn_dir = dir;
    c.coil_nibble = nib[3:0];
    return c;
  endfunction

  function automatic cmd_t gen_cmd(input bit on_stepper);
    int unsigned r;
    int unsigned k;
    cmd_t c;
    r = $urandom_range(0, 99);
    if (on_stepper) k = (r < 15) ? 0 : (r < 55) ? 1 : (r < 85) ? 3 : 2;
    else k = (r < 25) ? 0 : (r < 88) ? 1 : (r < 94) ? 2 : 3;
    c.kind = msds_pkg::kind_e'(k);
    if ($urandom_range(0, 3) == 0) c.duty_percent = 8'($urandom_range(95, 105));
    else c.duty_percent = 8'($urandom_range(0, 255));
    c.turn_dir = 1'($urandom_range(0, 1));
    c.coil_nibble = 4'($urandom_range(0, 15));
    if ($urandom_range(0, 99) < 12) c.unit = 3'($urandom_range(0, 7));
    else if (k <= 1) c.unit = 3'($urandom_range(1, on_stepper ? 2 : 4));
    else c.unit = msds_pkg::StepperTwo;
    return c;
  endfunction

  function automatic string res_str(input res_t r);
    return $sformatf("ser=%0b latch=%0b acc=%0b dw=%0b ch=%0d val=%0d pins=%0b last=%0b",
                     r.ser_bit, r.is_latch, r.accepted, r.duty_write, r.duty_channel,
                     r.duty_value, r.stepper_pins_on, r.last);
  endfunction

  // update the shadow for one command and queue the items it should produce
  task automatic bridge_apply(input cmd_t c);
    logic [2:0] um;
    logic [1:0] m;
    logic [7:0] la;
    logic [7:0] lb;
    logic [7:0] coils;
    logic       motor_unit;
    logic       ok;
    logic       duty_cmd;
    logic [6:0] dval;
    res_t       r;
    um = c.unit - 3'd1;
    m = um[1:0];
    la = LineA[m * 8 +: 8];
    lb = LineB[m * 8 +: 8];
    coils = {c.coil_nibble[3], c.coil_nibble[1], c.coil_nibble[2], 4'b0000, c.coil_nibble[0]};
    motor_unit = (c.unit >= 3'd1) && (c.unit <= msds_pkg::MotorUnitMax);
    ok = 1'b0;
    duty_cmd = 1'b0;
    dval = '0;
    case (c.kind)
      msds_pkg::KIND_MOTOR_EN: begin
        if (motor_unit && !(m[1] && stepper_two_on)) begin
          ok = 1'b1;
          bridge_shadow = bridge_shadow & ~(la | lb);
          motor_on[m] = 1'b1;
        end
      end
      msds_pkg::KIND_MOTOR_RUN: begin
        if (motor_unit && motor_on[m]) begin
          ok = 1'b1;
          duty_cmd = 1'b1;
          dval = (c.duty_percent > 8'(msds_pkg::DutyMax)) ? msds_pkg::DutyMax
                                                           : c.duty_percent[6:0];
          bridge_shadow = (bridge_shadow & ~(la | lb)) | (c.turn_dir ? la : lb);
        end
      end
      msds_pkg::KIND_STEP_EN: begin
        if (c.unit == msds_pkg::StepperTwo
            && (motor_on & msds_pkg::Motor34Mask) == 4'd0) begin
          ok = 1'b1;
          bridge_shadow = bridge_shadow & ~msds_pkg::Step2Mask;
          stepper_two_on = 1'b1;
        end
      end
      default: begin
        if (c.unit == msds_pkg::StepperTwo && stepper_two_on) begin
          ok = 1'b1;
          bridge_shadow = (bridge_shadow & ~msds_pkg::Step2Mask) | coils;
        end
      end
    endcase
    if (!ok) begin
      cmds_refused++;
      r = '0;
      r.last = 1'b1;
      serial_q.push_back(r);
    end else begin
      cmds_ok++;
      if (duty_cmd) duty_runs++;
      for (int i = 0; i < 8; i++) begin
        r = '0;
        r.ser_bit = bridge_shadow[7 - i];
        if (duty_cmd && i == 0) begin
          r.duty_write = 1'b1;
          r.duty_channel = c.unit;
        end
        serial_q.push_back(r);
      end
      r = '0;
      r.is_latch = 1'b1;
      r.accepted = 1'b1;
      r.duty_write = duty_cmd;
      r.duty_channel = duty_cmd ? c.unit : 3'd0;
      r.duty_value = dval;
      r.stepper_pins_on = (c.kind == msds_pkg::KIND_STEP_EN);
      r.last = 1'b1;
      serial_q.push_back(r);
    end
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // command driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_if.valid <= 1'b0;
      cmd_if.kind <= msds_pkg::KIND_MOTOR_EN;
      cmd_if.unit <= '0;
      cmd_if.duty_percent <= '0;
      cmd_if.turn_dir <= 1'b0;
      cmd_if.coil_nibble <= '0;
      send_gap <= 0;
    end else begin
      next_valid = cmd_if.valid;
      if (cmd_if.valid && cmd_if.ready) begin
        bridge_apply(cur_cmd);
        cmds_taken++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
        end else if (pending_q.size() != 0) begin
          cur_cmd = pending_q.pop_front();
          cmd_if.kind <= cur_cmd.kind;
          cmd_if.unit <= cur_cmd.unit;
          cmd_if.duty_percent <= cur_cmd.duty_percent;
          cmd_if.turn_dir <= cur_cmd.turn_dir;
          cmd_if.coil_nibble <= cur_cmd.coil_nibble;
          next_valid = 1'b1;
          send_gap <= pick_gap((cycle_count % 3000) < 500);
        end
      end
      cmd_if.valid <= next_valid;
    end
  end

  // long receiver hold-off so the command queue fills and ready drops
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_off <= 1'b0;
      hold_done <= 1'b0;
      hold_cnt <= 0;
    end else if (!hold_done && !hold_off && cmds_taken >= HoldAfterCmds) begin
      hold_off <= 1'b1;
      hold_cnt <= HoldCycles;
    end else if (hold_off) begin
      if (hold_cnt == 0) begin
        hold_off <= 1'b0;
        hold_done <= 1'b1;
      end else begin
        hold_cnt <= hold_cnt - 1;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      recv_gap <= 0;
    end else if (recv_gap != 0) begin
      recv_gap <= recv_gap - 1;
      res_if.ready <= 1'b0;
    end else if (hold_off) begin
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
      recv_gap <= pick_gap((cycle_count % 2500) >= 2000);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = {res_if.ser_bit, res_if.is_latch, res_if.accepted, res_if.duty_write,
             res_if.duty_channel, res_if.duty_value, res_if.stepper_pins_on, res_if.last};
      if (serial_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("tb: unexpected item: %s", res_str(got));
      end else begin
        want = serial_q.pop_front();
        items_checked++;
        if (got !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("tb: mismatch on item %0d", items_checked);
            $display("  expected %s", res_str(want));
            $display("  actual   %s", res_str(got));
          end
        end
      end
    end
  end

  initial begin
    int unsigned total;
    rst_ni = 1'b0;
    cmd_if.valid = 1'b0;
    cmd_if.kind = msds_pkg::KIND_MOTOR_EN;
    cmd_if.unit = '0;
    cmd_if.duty_percent = '0;
    cmd_if.turn_dir = 1'b0;
    cmd_if.coil_nibble = '0;
    res_if.ready = 1'b0;
    bridge_shadow = '0;
    motor_on = '0;
    stepper_two_on = 1'b0;
    stepper_side = $urandom_range(0, 1);

    // refusals from reset state
    pending_q.push_back(mk_cmd(msds_pkg::KIND_MOTOR_RUN, 1, 50, 1, 0));
    pending_q.push_back(mk_cmd(msds_pkg::KIND_MOTOR_EN, 0, 0, 0, 0));
    pending_q.push_back(mk_cmd(msds_pkg::KIND_MOTOR_EN, 5, 0, 0, 0));
    pending_q.push_back(mk_cmd(msds_pkg::KIND_MOTOR_RUN, 7, 255, 1, 15));
    pending_q.push_back(mk_cmd(msds_pkg::KIND_STEP_EN, 1, 0, 0, 0));
    pending_q.push_back(mk_cmd(msds_pkg::KIND_STEP_BITS, 2, 0, 0, 15));
    // motors 1 and 2 with duty extremes
    pending_q.push_back(mk_cmd(msds_pkg::KIND_MOTOR_EN, 1, 0, 0, 0));
    pending_q.push_back(mk_cmd(msds_pkg::KIND_MOTOR_EN, 2, 0, 0, 0));
    pending_q.push_back(mk_cmd(msds_pkg::KIND_MOTOR_RUN, 1, 255, 1, 0));
    pending_q.push_back(mk_cmd(msds_pkg::KIND_MOTOR_RUN, 2, 0, 0, 0));
    pending_q.push_back(mk_cmd(msds_pkg::KIND_MOTOR_RUN, 1, 100, 0, 0));
    pending_q.push_back(mk_cmd(msds_pkg::KIND_MOTOR_RUN, 2, 101, 1, 0));
    pending_q.push_back(mk_cmd(msds_pkg::KIND_MOTOR_EN, 1, 0, 0, 0));
    // stepper 2 and motors 3/4 share bridge lines: the seed picks which side claims them
    if (stepper_side) begin
      pending_q.push_back(mk_cmd(msds_pkg::KIND_STEP_EN, 2, 0, 0, 0));
      pending_q.push_back(mk_cmd(msds_pkg::KIND_STEP_EN, 2, 0, 0, 0));
      pending_q.push_back(mk_cmd(msds_pkg::KIND_STEP_BITS, 2, 0, 0, 15));
      pending_q.push_back(mk_cmd(msds_pkg::KIND_STEP_BITS, 2, 0, 0, 0));
      pending_q.push_back(mk_cmd(msds_pkg::KIND_STEP_BITS, 2, 0, 0, 5));
      pending_q.push_back(mk_cmd(msds_pkg::KIND_STEP_BITS, 2, 0, 0, 10));
      pending_q.push_back(mk_cmd(msds_pkg::KIND_MOTOR_EN, 3, 0, 0, 0));
      pending_q.push_back(mk_cmd(msds_pkg::KIND_MOTOR_EN, 4, 0, 0, 0));
      pending_q.push_back(mk_cmd(msds_pkg::KIND_MOTOR_RUN, 4, 80, 1, 0));
      pending_q.push_back(mk_cmd(msds_pkg::KIND_STEP_BITS, 1, 0, 0, 3));
      pending_q.push_back(mk_cmd(msds_pkg::KIND_STEP_BITS, 6, 0, 0, 12));
    end else begin
      pending_q.push_back(mk_cmd(msds_pkg::KIND_MOTOR_EN, 3, 0, 0, 0));
      pending_q.push_back(mk_cmd(msds_pkg::KIND_MOTOR_EN, 4, 0, 0, 0));
      pending_q.push_back(mk_cmd(msds_pkg::KIND_MOTOR_RUN, 3, 50, 1, 0));
      pending_q.push_back(mk_cmd(msds_pkg::KIND_MOTOR_RUN, 4, 200, 0, 0));
      pending_q.push_back(mk_cmd(msds_pkg::KIND_STEP_EN, 2, 0, 0, 0));
      pending_q.push_back(mk_cmd(msds_pkg::KIND_STEP_BITS, 2, 0, 0, 9));
      pending_q.push_back(mk_cmd(msds_pkg::KIND_STEP_EN, 3, 0, 0, 0));
      pending_q.push_back(mk_cmd(msds_pkg::KIND_MOTOR_RUN, 4, 7, 1, 0));
    end
    repeat (RandomCmds) pending_q.push_back(gen_cmd(stepper_side));
    total = pending_q.size();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmds_taken < total || serial_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    errors += serial_q.size();

    $display("summary: %0d commands (%0d accepted, %0d refused, %0d motor runs), %0d items checked",
             cmds_taken, cmds_ok, cmds_refused, duty_runs, items_checked);
    $display("summary: shared bridge lines held by %s, %0d errors",
             stepper_side ? "stepper 2" : "motors 3 and 4", errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
